/* hw/rtl/h5rx_pkg.sv */
`default_nettype none

package h5rx_pkg;

	localparam logic [7:0] DELIM    = 8'hC0;
	localparam logic [7:0] ESC      = 8'hDB;
	localparam logic [7:0] ESC_C0   = 8'hDC;
	localparam logic [7:0] ESC_DB   = 8'hDD;
	localparam logic [7:0] ESC_11   = 8'hDE;
	localparam logic [7:0] ESC_13   = 8'hDF;
	localparam logic [7:0] XON      = 8'h11;
	localparam logic [7:0] XOFF     = 8'h13;

	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [3:0] TYPE_MASK = 4'hF;
	localparam logic [2:0] SEQ_MASK  = 3'h7;

	localparam int unsigned HDR_BYTES = 4;
	localparam int unsigned CRC_BYTES = 2;
	localparam int unsigned MAX_OUT   = 28;
	localparam int unsigned LEN_MAX   = 31;
	localparam int unsigned PLEN_W    = 12;
	localparam int unsigned TOTAL_W   = 13;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_CHK   = 6'b000100,
		ST_ERD   = 6'b001000,
		ST_ELD   = 6'b010000,
		ST_EHOLD = 6'b100000
	} state_t;

	// One byte of the reflected CRC-16-CCITT, least significant bit first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ b[i]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic [15:0] rev16(input logic [15:0] v);
		logic [15:0] r;
		for (int i = 0; i < 16; i++) begin
			r[i] = v[15 - i];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/three_wire_uart_rx_deframer_unit.sv */
// Receive deframer for a three-wire UART link with SLIP-style framing.
// Raw bytes enter on the rx channel (rx_valid, rx_stall, rx_byte); one word is
// one received byte. Each decoded frame leaves on the res channel (res_valid,
// res_stall and the result fields) as one word per payload byte, or a single
// word when the payload is empty, with last set on the final word.
// Ordinary bytes are taken one per cycle while rx_stall is low and written
// straight into the frame buffer. The closing delimiter starts a check pass that
// reads the buffer one byte per cycle through its single read port, feeding the
// CRC unit, during which rx_stall is high. A valid frame then loads each word
// in ST_ELD (the first after ST_ERD) and offers it in ST_EHOLD until it is
// taken, before the next word is loaded; rx_stall stays high until the last word is taken.
// A stalled word holds its value until it is taken. Invalid frames give no
// word and the block returns to taking bytes straight after the check.
// Reset clears the framing state and the sequencer; the buffer needs no
// clearing, since only bytes written in the current frame are ever read.
`default_nettype none

module three_wire_uart_rx_deframer_unit #(
	parameter int unsigned BUFFER_BYTES = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_stall,
	input  wire logic [7:0] rx_byte,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic [3:0]      packet_type,
	output logic [2:0]      seq_number,
	output logic            is_reliable,
	output logic            crc_present,
	output logic [4:0]      payload_len,
	output logic [7:0]      payload_byte,
	output logic [4:0]      byte_pos,
	output logic            last
);

	localparam int unsigned AW = $clog2(BUFFER_BYTES);
	localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);

	h5rx_pkg::state_t state_q;

	logic [CW-1:0] fill_q;
	logic          in_frame_q;
	logic          esc_q;

	logic [7:0]    mem [BUFFER_BYTES];
	logic [7:0]    rdata_q;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [7:0]    wr_data;

	logic [CW-1:0] scan_q;
	logic          vld_s1;
	logic [CW-1:0] idx_s1;

	logic [7:0]    h0_q, h1_q, h2_q, h3_q;
	logic [15:0]   crc_q;
	logic [7:0]    got_hi_q, got_lo_q;

	logic          has_crc_q;
	logic [4:0]    plen_sat_q;
	logic [4:0]    cnt_q;
	logic          empty_q;
	logic [4:0]    e_q;

	logic          rx_acc, res_acc;
	logic [CW-1:0] fill_m2;
	logic [7:0]    hsum;
	logic [h5rx_pkg::PLEN_W-1:0]  plen;
	logic [h5rx_pkg::TOTAL_W-1:0] total;
	logic          frame_ok;
	logic [4:0]    e_rd;
	logic [6:0]    e_addr;

	assign rx_stall  = (state_q != h5rx_pkg::ST_IDLE);
	assign rx_acc    = rx_valid && !rx_stall;
	assign res_valid = (state_q == h5rx_pkg::ST_EHOLD);
	assign res_acc   = res_valid && !res_stall;

	assign packet_type = h1_q[3:0] & h5rx_pkg::TYPE_MASK;
	assign seq_number  = h0_q[2:0] & h5rx_pkg::SEQ_MASK;
	assign is_reliable = h0_q[7];
	assign crc_present = has_crc_q;
	assign payload_len = plen_sat_q;

	// Byte-level unstuffing of an accepted word; decides what goes into the buffer.
	always_comb begin
		wr_en   = 1'b0;
		wr_data = rx_byte;
		if (rx_acc && rx_byte != h5rx_pkg::DELIM && in_frame_q
		    && fill_q < CW'(BUFFER_BYTES)) begin
			if (esc_q) begin
				unique case (rx_byte)
					h5rx_pkg::ESC_C0: begin wr_en = 1'b1; wr_data = h5rx_pkg::DELIM; end
					h5rx_pkg::ESC_DB: begin wr_en = 1'b1; wr_data = h5rx_pkg::ESC; end
					h5rx_pkg::ESC_11: begin wr_en = 1'b1; wr_data = h5rx_pkg::XON; end
					h5rx_pkg::ESC_13: begin wr_en = 1'b1; wr_data = h5rx_pkg::XOFF; end
					default: begin wr_en = 1'b0; end
				endcase
			end else if (rx_byte != h5rx_pkg::ESC) begin
				wr_en = 1'b1;
			end
		end
	end

	assign e_rd   = (state_q == h5rx_pkg::ST_EHOLD) ? (e_q + 5'd1) : e_q;
	assign e_addr = 7'(e_rd) + 7'(h5rx_pkg::HDR_BYTES);
	assign rd_addr = (state_q == h5rx_pkg::ST_SCAN) ? scan_q[AW-1:0] : e_addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q[AW-1:0]] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	// Frame check on the values gathered by the scan.
	assign fill_m2 = fill_q - CW'(2);
	assign hsum    = h0_q + h1_q + h2_q;
	assign plen    = {h2_q, h1_q[7:4]};
	assign total   = h5rx_pkg::TOTAL_W'(plen) + h5rx_pkg::TOTAL_W'(h5rx_pkg::HDR_BYTES)
	               + (h0_q[6] ? h5rx_pkg::TOTAL_W'(h5rx_pkg::CRC_BYTES) : '0);
	assign frame_ok = (~hsum == h3_q) && (total == h5rx_pkg::TOTAL_W'(fill_q))
	               && (!h0_q[6] || {got_hi_q, got_lo_q} == h5rx_pkg::rev16(crc_q));

	// Data returned by the scan: header bytes, CRC input and the trailing CRC.
	always_ff @(posedge clk) begin
		if (state_q == h5rx_pkg::ST_IDLE) begin
			crc_q <= h5rx_pkg::CRC_INIT;
		end else if (vld_s1) begin
			if (idx_s1 == CW'(0)) h0_q <= rdata_q;
			if (idx_s1 == CW'(1)) h1_q <= rdata_q;
			if (idx_s1 == CW'(2)) h2_q <= rdata_q;
			if (idx_s1 == CW'(3)) h3_q <= rdata_q;
			if (idx_s1 < fill_m2) crc_q <= h5rx_pkg::crc_byte(crc_q, rdata_q);
			if (idx_s1 == fill_m2) got_hi_q <= rdata_q;
			if (idx_s1 == fill_q - CW'(1)) got_lo_q <= rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == h5rx_pkg::ST_CHK) begin
			has_crc_q  <= h0_q[6];
			empty_q    <= (plen == '0);
			plen_sat_q <= (plen > h5rx_pkg::PLEN_W'(h5rx_pkg::LEN_MAX))
			              ? 5'(h5rx_pkg::LEN_MAX) : plen[4:0];
			if (plen == '0) begin
				cnt_q <= 5'd1;
			end else if (plen > h5rx_pkg::PLEN_W'(h5rx_pkg::MAX_OUT)) begin
				cnt_q <= 5'(h5rx_pkg::MAX_OUT);
			end else begin
				cnt_q <= plen[4:0];
			end
		end
		if (state_q == h5rx_pkg::ST_ELD) begin
			payload_byte <= empty_q ? 8'd0 : rdata_q;
			byte_pos     <= empty_q ? 5'd0 : e_q;
			last         <= (e_q + 5'd1 == cnt_q);
		end
		idx_s1 <= scan_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= h5rx_pkg::ST_IDLE;
			fill_q     <= '0;
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			scan_q     <= '0;
			vld_s1     <= 1'b0;
			e_q        <= '0;
		end else begin
			vld_s1 <= (state_q == h5rx_pkg::ST_SCAN) && (scan_q != fill_q);
			unique case (state_q)
				h5rx_pkg::ST_IDLE: begin
					scan_q <= '0;
					e_q    <= '0;
					if (rx_acc) begin
						if (rx_byte == h5rx_pkg::DELIM) begin
							esc_q <= 1'b0;
							if (!in_frame_q) begin
								in_frame_q <= 1'b1;
								fill_q     <= '0;
							end else begin
								// Closing delimiter; fill_q is kept for the check.
								in_frame_q <= 1'b0;
								if (fill_q >= CW'(h5rx_pkg::HDR_BYTES)) begin
									state_q <= h5rx_pkg::ST_SCAN;
								end
							end
						end else if (in_frame_q && fill_q < CW'(BUFFER_BYTES)) begin
							if (esc_q) begin
								if (wr_en) begin
									esc_q  <= 1'b0;
									fill_q <= fill_q + CW'(1);
								end else begin
									in_frame_q <= 1'b0;
									esc_q      <= 1'b0;
									fill_q     <= '0;
								end
							end else if (rx_byte == h5rx_pkg::ESC) begin
								esc_q <= 1'b1;
							end else begin
								fill_q <= fill_q + CW'(1);
							end
						end
					end
				end
				h5rx_pkg::ST_SCAN: begin
					if (scan_q != fill_q) begin
						scan_q <= scan_q + CW'(1);
					end else begin
						state_q <= h5rx_pkg::ST_CHK;
					end
				end
				h5rx_pkg::ST_CHK: begin
					state_q <= frame_ok ? h5rx_pkg::ST_ERD : h5rx_pkg::ST_IDLE;
				end
				h5rx_pkg::ST_ERD: begin
					state_q <= h5rx_pkg::ST_ELD;
				end
				h5rx_pkg::ST_ELD: begin
					state_q <= h5rx_pkg::ST_EHOLD;
				end
				h5rx_pkg::ST_EHOLD: begin
					if (res_acc) begin
						if (last) begin
							state_q <= h5rx_pkg::ST_IDLE;
						end else begin
							e_q     <= e_q + 5'd1;
							state_q <= h5rx_pkg::ST_ELD;
						end
					end
				end
				default: begin
					state_q <= h5rx_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
